// ===== sv/srmq_pkg.sv =====
// Shared types, constants and helpers for the sparse-table range-minimum block.
package srmq_pkg;

    localparam int MAX_ELEMS_DEF = 1024;
    localparam int LEVELS_DEF    = 11;

    localparam int VALUE_W = 64;
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int INDEX_W = 10;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [START_W-1:0]        range_start;
        logic [END_W-1:0]          range_end;
    } srmq_in_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] min_index;
    } srmq_out_t;

    // Position of the highest set bit; zero for an input of zero or one.
    function automatic logic [3:0] floor_log2(input logic [END_W-1:0] x);
        logic [3:0] r;
        r = '0;
        for (int i = 1; i < END_W; i++) begin
            if (x[i]) begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/sparse_table_range_min.sv =====
// Sparse-table range-minimum block: element store, level table and the sequencer around them.
//
// Load words (kind 0) write one signed 64-bit element each, and the element's level-0
// table entry is written in the same cycle. The word with last set closes the data
// set and starts the table build, during which s_ready stays low. The build runs
// every entry of levels 1 and up through one shared path: read two lower-level
// indices from the level table, read their two elements from the element store,
// compare signed and write the winner (ties keep the left index). Each entry passes
// address setup, level-table read, element read and compare in turn, with the two
// memory reads in series in that path, and each level opens with a level check. A
// query word (kind 1) takes the same path once: range check, window level and
// address setup, level-table read, element read, compare, then the result goes into
// the output register, which waits while an earlier result is still held there; the
// block is ready again once the result is in it (an empty, reversed or out-of-range
// query skips the lookup). Empty, reversed or out-of-range queries answer found = 0,
// min_index = 0. Loads past MAX_ELEMS are dropped; a new load after a build replaces
// the data set, and queries before its last word answer found = 0.
// Both memories have no reset and need no clearing pass: no valid query reads an entry
// that the current data set did not write.
module sparse_table_range_min
    import srmq_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF,
    parameter int LEVELS    = LEVELS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  srmq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output srmq_out_t m_data
);

    localparam int IDX_W     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int TAB_DEPTH = LEVELS * MAX_ELEMS;
    localparam int TAB_W     = $clog2(TAB_DEPTH);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int SPN_W     = LEVELS;
    localparam int CMP_W     = ((SPN_W > CNT_W) ? SPN_W : CNT_W) + 1;
    localparam int QW        = ((END_W > CNT_W) ? END_W : CNT_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_LEVEL,
        ST_B_ADDR,
        ST_RD_L,
        ST_RD_E,
        ST_CMP,
        ST_Q_CHK,
        ST_Q_BASE,
        ST_OUT
    } state_t;

    // Storage: element store and level table, one write port and two read ports each.
    logic signed [VALUE_W-1:0] elem_mem [MAX_ELEMS];
    logic [IDX_W-1:0]          lt_mem   [TAB_DEPTH];

    state_t                    state_reg;
    logic                      build_reg;     // sequencer is building, not answering
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          ptr_reg;

    logic [LVL_W-1:0]          lvl_reg;
    logic [SPN_W-1:0]          span_reg;
    logic [SPN_W-1:0]          half_reg;
    logic [TAB_W-1:0]          base_prev_reg;
    logic [TAB_W-1:0]          base_cur_reg;
    logic [IDX_W-1:0]          i_reg;
    logic [IDX_W-1:0]          last_i_reg;

    logic [START_W-1:0]        left_reg;
    logic [END_W-1:0]          right_reg;
    logic [IDX_W-1:0]          qb_reg;

    logic [TAB_W-1:0]          addr_a_reg;
    logic [TAB_W-1:0]          addr_b_reg;
    logic [IDX_W-1:0]          la_reg;
    logic [IDX_W-1:0]          lb_reg;
    logic signed [VALUE_W-1:0] ea_reg;
    logic signed [VALUE_W-1:0] eb_reg;

    logic                      found_reg;
    logic [INDEX_W-1:0]        idx_reg;
    logic                      m_valid_reg;
    srmq_out_t                 m_data_reg;

    logic                      s_fire;
    logic                      load_fire;
    logic                      room;
    logic [CNT_W-1:0]          ptr_next;
    logic [IDX_W-1:0]          sel;
    logic                      out_free;

    logic                      lt_we;
    logic [TAB_W-1:0]          lt_waddr;
    logic [IDX_W-1:0]          lt_wdata;

    logic [QW-1:0]             q_left;
    logic [QW-1:0]             q_right;
    logic [QW-1:0]             q_count;
    logic                      q_bad;
    logic [END_W-1:0]          q_len;
    logic [3:0]                q_log;
    logic [LVL_W-1:0]          q_lvl;
    logic [END_W-1:0]          q_win;

    logic [CMP_W-1:0]          b_span;
    logic [CMP_W-1:0]          b_count;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && (s_data.kind == KIND_LOAD);
    assign room      = (ptr_reg < CNT_W'(MAX_ELEMS));
    assign ptr_next  = room ? ptr_reg + CNT_W'(1) : ptr_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Leftmost minimum of the two looked-up indices.
    assign sel = (ea_reg <= eb_reg) ? la_reg : lb_reg;

    // Query range check and window level.
    assign q_left  = QW'(left_reg);
    assign q_right = QW'(right_reg);
    assign q_count = QW'(count_reg);
    assign q_bad   = (count_reg == '0) || (q_left >= q_right) || (q_right > q_count);
    assign q_len   = right_reg - END_W'(left_reg);
    assign q_log   = floor_log2(q_len);
    assign q_lvl   = (int'(q_log) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(q_log);
    assign q_win   = END_W'(1) << q_lvl;

    assign b_span  = CMP_W'(span_reg);
    assign b_count = CMP_W'(count_reg);

    // Level-table write: level 0 during loads, higher levels from the build compare.
    always_comb begin
        lt_we    = 1'b0;
        lt_waddr = base_cur_reg + TAB_W'(i_reg);
        lt_wdata = sel;
        if (load_fire && room) begin
            lt_we    = 1'b1;
            lt_waddr = TAB_W'(ptr_reg[IDX_W-1:0]);
            lt_wdata = ptr_reg[IDX_W-1:0];
        end else if (state_reg == ST_CMP && build_reg) begin
            lt_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire && room) begin
            elem_mem[ptr_reg[IDX_W-1:0]] <= s_data.value;
        end
        if (state_reg == ST_RD_E) begin
            ea_reg <= elem_mem[la_reg];
            eb_reg <= elem_mem[lb_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (lt_we) begin
            lt_mem[lt_waddr] <= lt_wdata;
        end
        if (state_reg == ST_RD_L) begin
            la_reg <= lt_mem[addr_a_reg];
            lb_reg <= lt_mem[addr_b_reg];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            build_reg   <= 1'b0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.kind == KIND_LOAD) begin
                            // Open a new data set on its first word.
                            if (ptr_reg == '0) begin
                                count_reg <= '0;
                            end
                            if (s_data.last) begin
                                count_reg     <= ptr_next;
                                ptr_reg       <= '0;
                                build_reg     <= 1'b1;
                                lvl_reg       <= LVL_W'(1);
                                span_reg      <= SPN_W'(2);
                                half_reg      <= SPN_W'(1);
                                base_prev_reg <= '0;
                                base_cur_reg  <= TAB_W'(MAX_ELEMS);
                                state_reg     <= ST_B_LEVEL;
                            end else begin
                                ptr_reg <= ptr_next;
                            end
                        end else begin
                            build_reg <= 1'b0;
                            left_reg  <= s_data.range_start;
                            right_reg <= s_data.range_end;
                            state_reg <= ST_Q_CHK;
                        end
                    end
                end
                ST_B_LEVEL: begin
                    if (b_span > b_count) begin
                        build_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end else begin
                        last_i_reg <= IDX_W'(b_count - b_span);
                        i_reg      <= '0;
                        state_reg  <= ST_B_ADDR;
                    end
                end
                ST_B_ADDR: begin
                    addr_a_reg <= base_prev_reg + TAB_W'(i_reg);
                    addr_b_reg <= base_prev_reg + TAB_W'(i_reg) + TAB_W'(half_reg);
                    state_reg  <= ST_RD_L;
                end
                ST_RD_L: begin
                    state_reg <= ST_RD_E;
                end
                ST_RD_E: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (build_reg) begin
                        if (i_reg != last_i_reg) begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_B_ADDR;
                        end else if (lvl_reg == LVL_W'(LEVELS - 1)) begin
                            build_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            // Advance to the next level.
                            lvl_reg       <= lvl_reg + LVL_W'(1);
                            span_reg      <= span_reg << 1;
                            half_reg      <= half_reg << 1;
                            base_prev_reg <= base_cur_reg;
                            base_cur_reg  <= base_cur_reg + TAB_W'(MAX_ELEMS);
                            state_reg     <= ST_B_LEVEL;
                        end
                    end else begin
                        found_reg <= 1'b1;
                        idx_reg   <= INDEX_W'(sel);
                        state_reg <= ST_OUT;
                    end
                end
                ST_Q_CHK: begin
                    if (q_bad) begin
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        lvl_reg   <= q_lvl;
                        qb_reg    <= IDX_W'(right_reg - q_win);
                        state_reg <= ST_Q_BASE;
                    end
                end
                ST_Q_BASE: begin
                    addr_a_reg <= TAB_W'(lvl_reg) * TAB_W'(MAX_ELEMS) + TAB_W'(left_reg);
                    addr_b_reg <= TAB_W'(lvl_reg) * TAB_W'(MAX_ELEMS) + TAB_W'(qb_reg);
                    state_reg  <= ST_RD_L;
                end
                ST_OUT: begin
                    // Hold the result until the output register is free.
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.found     <= found_reg;
                        m_data_reg.min_index <= idx_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
